@@ hw/rtl/fsc_pkg.sv @@
package fsc_pkg;

   localparam int NUM_WHEELS = 2;

   // 60e6 / period gives RPM from a period in microseconds
   localparam logic [25:0] RPM_NUMERATOR = 26'd60000000;
   localparam logic [13:0] SPEED_MAX     = 14'd16383;
   // periods at or below this give a speed of 16384 or more
   localparam logic [20:0] SPEED_SAT_PERIOD = 21'(RPM_NUMERATOR >> 14);
   // error above 0.1 in Q2.14 (err * 10 > 16384)
   localparam logic [15:0] BRAKE_LIMIT = 16'd1638;
   localparam logic [15:0] DUTY_FULL   = 16'd32768;
   localparam logic [15:0] ERR_POS_SAT = 16'h7FFF;
   localparam logic [15:0] ERR_NEG_SAT = 16'h8000;

   // register indexes
   localparam logic [2:0] REG_MAX_SPEED       = 3'd0;
   localparam logic [2:0] REG_SETPOINT_NORMAL = 3'd1;
   localparam logic [2:0] REG_SETPOINT_HIGH   = 3'd2;
   localparam logic [2:0] REG_GAIN            = 3'd3;
   localparam logic [2:0] REG_TOLERANCE       = 3'd4;
   localparam logic [2:0] REG_REQUIRED_CYCLES = 3'd5;
   localparam logic [2:0] REG_BATTERY_FULL    = 3'd6;

   localparam logic [27:0] RST_MAX_SPEED       = 28'd98311400;
   localparam logic [27:0] RST_SETPOINT_NORMAL = 28'd80286900;
   localparam logic [27:0] RST_SETPOINT_HIGH   = 28'd45877276;
   localparam logic [31:0] RST_GAIN            = 32'd268439552;
   localparam logic [31:0] RST_TOLERANCE       = 32'd42951311;
   localparam logic [7:0]  RST_REQUIRED_CYCLES = 8'd3;
   localparam logic [13:0] RST_BATTERY_FULL    = 14'd12000;

   // divider operations
   localparam logic [1:0] DIV_SPEED = 2'd0;
   localparam logic [1:0] DIV_ERR   = 2'd1;
   localparam logic [1:0] DIV_FF    = 2'd2;
   localparam logic [1:0] DIV_DUTY  = 2'd3;

   localparam int DIV_W  = 21;   // widest divisor (period)
   localparam int FEED_W = 28;   // widest dividend fed bit by bit
   localparam int CNT_W  = 5;

   typedef struct packed {
      logic [27:0] max_speed_pair;
      logic [27:0] setpoint_normal_pair;
      logic [27:0] setpoint_high_pair;
      logic [31:0] gain_pair;
      logic [31:0] tolerance_pair;
      logic [7:0]  required_cycles;
      logic [13:0] battery_full_mv;
   } cfg_type;

   typedef struct packed {
      logic       load_item;
      logic       div_start;
      logic [1:0] div_op;
      logic       speed_direct;
      logic       err_sat;
      logic       mul_corr;
      logic       calc_drive;
      logic       mul_duty;
      logic       duty_sat;
      logic       write_out;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic speed_direct;
      logic err_sat;
      logic duty_sat;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/fsc_divider.sv @@
module fsc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsc_pkg::DIV_W-1:0]       rem_init,
   input  logic [fsc_pkg::FEED_W-1:0]      feed,
   input  logic [fsc_pkg::CNT_W-1:0]       count,
   input  logic [fsc_pkg::DIV_W-1:0]       divisor,
   output logic [fsc_pkg::FEED_W-1:0]      quotient,
   output logic                            done
);
   import fsc_pkg::*;

   // restoring radix-2 divider; rem_init must be below divisor
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [FEED_W-1:0]  feed_ff, feed_in;
   logic [FEED_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIV_W:0]     trial;
   logic               fits;

   always_comb begin
      trial = {rem_ff, feed_ff[FEED_W-1]};
      fits  = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      feed_in = feed_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = count;
         rem_in  = rem_init;
         feed_in = feed;
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
         quo_in  = {quo_ff[FEED_W-2:0], fits};
         feed_in = {feed_ff[FEED_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      feed_ff <= feed_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ hw/rtl/fsc_datapath.sv @@
module fsc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  fsc_pkg::cfg_type      cfg,
   input  fsc_pkg::cmd_type      cmd,
   output fsc_pkg::status_type   status,
   input  logic                  req_wheel,
   input  logic [20:0]           req_period_us,
   input  logic                  req_stopped,
   input  logic                  req_high_angle,
   input  logic [13:0]           req_battery_mv,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_wheel_out,
   output logic [15:0]           rsp_duty,
   output logic                  rsp_brake,
   output logic                  rsp_at_speed,
   output logic signed [15:0]    rsp_error_norm,
   output logic [13:0]           rsp_speed_rpm
);
   import fsc_pkg::*;

   // item registers
   logic        wheel_ff, stopped_ff, high_ff;
   logic [20:0] period_ff;
   logic [13:0] bat_ff;

   // working registers
   logic [1:0]  div_op_ff;
   logic [13:0] speed_ff, speed_in;
   logic [15:0] err_ff, err_in;
   logic [27:0] ff_ff;
   logic [19:0] corr_ff;
   logic [28:0] drive_ff, drive_in;
   logic [43:0] num_ff;
   logic [15:0] duty_ff, duty_in;

   // tolerance counters and result register
   logic [7:0]  cnt_ff [NUM_WHEELS];
   logic [7:0]  cnt_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_wheel_ff, out_brake_ff, out_at_ff;
   logic [15:0] out_duty_ff, out_err_ff;
   logic [13:0] out_speed_ff;

   logic [13:0] maxs_raw, maxs, sp, full;
   logic [15:0] gain, tol;
   logic [16:0] bat5;
   logic [14:0] diff;
   logic        diff_neg;
   logic [13:0] mag_d;
   logic [15:0] err_mag;
   logic [31:0] corr_prod;
   logic [14:0] q15;
   logic        in_tol, at_speed;

   logic [DIV_W-1:0]  div_rem, div_den;
   logic [FEED_W-1:0] div_feed, div_quo;
   logic [CNT_W-1:0]  div_cnt;
   logic              div_done;

   always_comb begin
      maxs_raw = wheel_ff ? cfg.max_speed_pair[27:14] : cfg.max_speed_pair[13:0];
      maxs     = (maxs_raw == 14'd0) ? 14'd1 : maxs_raw;
      if (high_ff) begin
         sp = wheel_ff ? cfg.setpoint_high_pair[27:14] : cfg.setpoint_high_pair[13:0];
      end else begin
         sp = wheel_ff ? cfg.setpoint_normal_pair[27:14] : cfg.setpoint_normal_pair[13:0];
      end
      gain = wheel_ff ? cfg.gain_pair[31:16] : cfg.gain_pair[15:0];
      tol  = wheel_ff ? cfg.tolerance_pair[31:16] : cfg.tolerance_pair[15:0];
      full = (cfg.battery_full_mv == 14'd0) ? 14'd1 : cfg.battery_full_mv;
      bat5 = {3'b000, bat_ff} * 17'd5;

      diff     = {1'b0, speed_ff} - {1'b0, sp};
      diff_neg = diff[14];
      mag_d    = diff_neg ? 14'(-diff) : diff[13:0];
      err_mag  = err_ff[15] ? 16'(~err_ff + 16'd1) : err_ff;
      corr_prod = err_mag * gain;
      q15       = div_quo[14:0];

      status.reject       = (period_ff == 21'd0) || (bat5 < {3'b000, full});
      status.speed_direct = stopped_ff || (period_ff <= SPEED_SAT_PERIOD);
      status.err_sat      = {1'b0, mag_d} >= {maxs, 1'b0};
      status.duty_sat     = num_ff[43:15] >= {15'd0, bat_ff};
      status.div_done     = div_done;
      status.out_free     = !out_valid_ff || !rsp_stall;
   end

   // divider operand selection
   always_comb begin
      case (cmd.div_op)
         DIV_SPEED: begin
            div_rem  = SPEED_SAT_PERIOD;
            div_feed = {RPM_NUMERATOR[13:0], 14'd0};
            div_cnt  = CNT_W'(14);
            div_den  = period_ff;
         end
         DIV_ERR: begin
            div_rem  = DIV_W'(mag_d[13:1]);
            div_feed = {mag_d[0], 27'd0};
            div_cnt  = CNT_W'(15);
            div_den  = DIV_W'(maxs);
         end
         DIV_FF: begin
            div_rem  = '0;
            div_feed = {sp, 14'd0};
            div_cnt  = CNT_W'(28);
            div_den  = DIV_W'(maxs);
         end
         DIV_DUTY: begin
            div_rem  = DIV_W'(num_ff[28:15]);
            div_feed = {num_ff[14:0], 13'd0};
            div_cnt  = CNT_W'(15);
            div_den  = DIV_W'(bat_ff);
         end
         default: begin
            div_rem  = '0;
            div_feed = '0;
            div_cnt  = CNT_W'(1);
            div_den  = DIV_W'(1);
         end
      endcase
   end

   fsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem),
      .feed     (div_feed),
      .count    (div_cnt),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   // captures
   always_comb begin
      speed_in = speed_ff;
      if (cmd.speed_direct) begin
         speed_in = stopped_ff ? 14'd0 : SPEED_MAX;
      end else if (div_done && div_op_ff == DIV_SPEED) begin
         speed_in = div_quo[13:0];
      end

      err_in = err_ff;
      if (cmd.err_sat) begin
         err_in = diff_neg ? ERR_NEG_SAT : ERR_POS_SAT;
      end else if (div_done && div_op_ff == DIV_ERR) begin
         err_in = diff_neg ? 16'(~{1'b0, q15} + 16'd1) : {1'b0, q15};
      end

      // truncation toward zero: subtract or add the magnitude
      if (err_ff[15]) begin
         drive_in = {1'b0, ff_ff} + {9'd0, corr_ff};
      end else if (ff_ff >= {8'd0, corr_ff}) begin
         drive_in = {1'b0, ff_ff - {8'd0, corr_ff}};
      end else begin
         drive_in = '0;
      end

      duty_in = duty_ff;
      if (cmd.duty_sat) begin
         duty_in = DUTY_FULL;
      end else if (div_done && div_op_ff == DIV_DUTY) begin
         duty_in = {1'b0, q15};
      end

      in_tol = {err_mag, 2'b00} < {2'b00, tol};
      if (in_tol) begin
         cnt_in = (cnt_ff[wheel_ff] == 8'hFF) ? 8'hFF : cnt_ff[wheel_ff] + 8'd1;
      end else begin
         cnt_in = 8'd0;
      end
      at_speed = in_tol && (cnt_in >= cfg.required_cycles);

      out_valid_in = out_valid_ff;
      if (cmd.write_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         wheel_ff   <= req_wheel;
         period_ff  <= req_period_us;
         stopped_ff <= req_stopped;
         high_ff    <= req_high_angle;
         bat_ff     <= req_battery_mv;
      end
      if (cmd.div_start) begin
         div_op_ff <= cmd.div_op;
      end
      speed_ff <= speed_in;
      err_ff   <= err_in;
      if (div_done && div_op_ff == DIV_FF) begin
         ff_ff <= div_quo;
      end
      if (cmd.mul_corr) begin
         corr_ff <= corr_prod[31:12];
      end
      if (cmd.calc_drive) begin
         drive_ff <= drive_in;
      end
      if (cmd.mul_duty) begin
         num_ff <= {43'(43'(drive_ff) * 43'(full)), 1'b0};
      end
      duty_ff <= duty_in;
      if (cmd.write_out) begin
         out_wheel_ff <= wheel_ff;
         out_duty_ff  <= duty_ff;
         out_brake_ff <= $signed(err_ff) > $signed(BRAKE_LIMIT);
         out_at_ff    <= at_speed;
         out_err_ff   <= err_ff;
         out_speed_ff <= speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            cnt_ff[i] <= 8'd0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.write_out) begin
            cnt_ff[wheel_ff] <= cnt_in;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_wheel_out  = out_wheel_ff;
   assign rsp_duty       = out_duty_ff;
   assign rsp_brake      = out_brake_ff;
   assign rsp_at_speed   = out_at_ff;
   assign rsp_error_norm = $signed(out_err_ff);
   assign rsp_speed_rpm  = out_speed_ff;

endmodule

@@ hw/rtl/fsc_control.sv @@
module fsc_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsc_pkg::status_type   status,
   output fsc_pkg::cmd_type      cmd
);
   import fsc_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_CHECK      = 4'd1;
   localparam logic [3:0] S_WAIT_SPEED = 4'd2;
   localparam logic [3:0] S_ERR        = 4'd3;
   localparam logic [3:0] S_WAIT_ERR   = 4'd4;
   localparam logic [3:0] S_FF         = 4'd5;
   localparam logic [3:0] S_WAIT_FF    = 4'd6;
   localparam logic [3:0] S_CORR       = 4'd7;
   localparam logic [3:0] S_DRIVE      = 4'd8;
   localparam logic [3:0] S_MUL_DUTY   = 4'd9;
   localparam logic [3:0] S_DUTY       = 4'd10;
   localparam logic [3:0] S_WAIT_DUTY  = 4'd11;
   localparam logic [3:0] S_OUT        = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_op = DIV_SPEED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.reject) begin
               state_in = S_IDLE;
            end else if (status.speed_direct) begin
               cmd.speed_direct = 1'b1;
               state_in = S_ERR;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_SPEED;
               state_in = S_WAIT_SPEED;
            end
         end
         S_WAIT_SPEED: begin
            if (status.div_done) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            if (status.err_sat) begin
               cmd.err_sat = 1'b1;
               state_in = S_FF;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_ERR;
               state_in = S_WAIT_ERR;
            end
         end
         S_WAIT_ERR: begin
            if (status.div_done) begin
               state_in = S_FF;
            end
         end
         S_FF: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_FF;
            state_in = S_WAIT_FF;
         end
         S_WAIT_FF: begin
            if (status.div_done) begin
               state_in = S_CORR;
            end
         end
         S_CORR: begin
            cmd.mul_corr = 1'b1;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            cmd.calc_drive = 1'b1;
            state_in = S_MUL_DUTY;
         end
         S_MUL_DUTY: begin
            cmd.mul_duty = 1'b1;
            state_in = S_DUTY;
         end
         S_DUTY: begin
            if (status.duty_sat) begin
               cmd.duty_sat = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_DUTY;
               state_in = S_WAIT_DUTY;
            end
         end
         S_WAIT_DUTY: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.write_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/fsc_csr.sv @@
module fsc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output fsc_pkg::cfg_type  cfg
);
   import fsc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   always_comb begin
      idx    = paddr[4:2];
      wr     = psel && penable && pwrite;
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_MAX_SPEED:       cfg_in.max_speed_pair       = pwdata[27:0];
            REG_SETPOINT_NORMAL: cfg_in.setpoint_normal_pair = pwdata[27:0];
            REG_SETPOINT_HIGH:   cfg_in.setpoint_high_pair   = pwdata[27:0];
            REG_GAIN:            cfg_in.gain_pair            = pwdata;
            REG_TOLERANCE:       cfg_in.tolerance_pair       = pwdata;
            REG_REQUIRED_CYCLES: cfg_in.required_cycles      = pwdata[7:0];
            REG_BATTERY_FULL:    cfg_in.battery_full_mv      = pwdata[13:0];
            default: ;
         endcase
      end
      case (idx)
         REG_MAX_SPEED:       prdata = {4'd0, cfg_ff.max_speed_pair};
         REG_SETPOINT_NORMAL: prdata = {4'd0, cfg_ff.setpoint_normal_pair};
         REG_SETPOINT_HIGH:   prdata = {4'd0, cfg_ff.setpoint_high_pair};
         REG_GAIN:            prdata = cfg_ff.gain_pair;
         REG_TOLERANCE:       prdata = cfg_ff.tolerance_pair;
         REG_REQUIRED_CYCLES: prdata = {24'd0, cfg_ff.required_cycles};
         REG_BATTERY_FULL:    prdata = {18'd0, cfg_ff.battery_full_mv};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed_pair       <= RST_MAX_SPEED;
         cfg_ff.setpoint_normal_pair <= RST_SETPOINT_NORMAL;
         cfg_ff.setpoint_high_pair   <= RST_SETPOINT_HIGH;
         cfg_ff.gain_pair            <= RST_GAIN;
         cfg_ff.tolerance_pair       <= RST_TOLERANCE;
         cfg_ff.required_cycles      <= RST_REQUIRED_CYCLES;
         cfg_ff.battery_full_mv      <= RST_BATTERY_FULL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

@@ hw/rtl/flywheel_speed_controller.sv @@
// Processing: the speed, error, feedforward and duty quotients come from the
//   shared radix-2 divider; divisions are skipped when speed, error or
//   duty saturate. A rejected item (zero period, low battery) gives no result.
// Throughput: one item at a time; the next transfer is taken
//   once the result is in the output register, which may still be waiting on rsp_stall.
// Reset (synchronous, active high) restores register defaults and clears both at-speed counters.
module flywheel_speed_controller (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_wheel,
   input  logic [20:0]        req_period_us,
   input  logic               req_stopped,
   input  logic               req_high_angle,
   input  logic [13:0]        req_battery_mv,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_wheel_out,
   output logic [15:0]        rsp_duty,
   output logic               rsp_brake,
   output logic               rsp_at_speed,
   output logic signed [15:0] rsp_error_norm,
   output logic [13:0]        rsp_speed_rpm,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import fsc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Configuration registers; the user must write them only while no item is in flight
   // (the block does not enforce this), so the datapath reads them directly.
   fsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: speed division, error division, feedforward division,
   // correction multiply, drive, duty multiply, duty division, result write.
   fsc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: item registers, one shared divider, two multipliers,
   // at-speed counters and the result register.
   fsc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_wheel      (req_wheel),
      .req_period_us  (req_period_us),
      .req_stopped    (req_stopped),
      .req_high_angle (req_high_angle),
      .req_battery_mv (req_battery_mv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_wheel_out  (rsp_wheel_out),
      .rsp_duty       (rsp_duty),
      .rsp_brake      (rsp_brake),
      .rsp_at_speed   (rsp_at_speed),
      .rsp_error_norm (rsp_error_norm),
      .rsp_speed_rpm  (rsp_speed_rpm)
   );

endmodule
